// ===== hw/rtl/drbc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the dark region area / boundary counter.
// No dependencies; every other file of the block but drbc_ram refers to this package.
package drbc_pkg;

  localparam int unsigned MaxSize  = 128;
  localparam int unsigned ColW     = (MaxSize > 1) ? $clog2(MaxSize) : 1;
  localparam int unsigned PixW     = 8;
  localparam int unsigned CfgW     = 8;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CountW   = 15;

  localparam logic [CountW-1:0] CountMax       = '1;
  localparam logic [CfgW-1:0]   SizeReset      = 8'd1;
  localparam logic [CfgW-1:0]   ThresholdReset = 8'd50;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  typedef enum logic [CfgIdxW-1:0] {
    RegImageSize     = 1'b0,
    RegDarkThreshold = 1'b1
  } cfg_reg_e;

  // One classified pixel, front to back
  typedef struct packed {
    logic            dark;
    logic            first_row;
    logic            first_col;
    logic            border;
    logic            last;
    logic [ColW-1:0] col;
  } item_t;

  // One line store entry: region pixel still undecided, and region bit
  typedef struct packed {
    logic older;
    logic newer;
  } line_t;

endpackage

// ===== hw/rtl/drbc_pix_if.sv =====
`timescale 1ns / 1ps
// Pixel stream channel: valid/ready handshake with one grey value per beat.
// Depends on drbc_pkg for the pixel width.
interface drbc_pix_if;
  logic                      valid;
  logic                      ready;
  logic [drbc_pkg::PixW-1:0] pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink   (input valid, input pixel_value, output ready);
endinterface

// ===== hw/rtl/drbc_res_if.sv =====
`timescale 1ns / 1ps
// Result channel: valid/ready handshake carrying both frame totals per beat.
// Depends on drbc_pkg for the count width.
interface drbc_res_if;
  logic                        valid;
  logic                        ready;
  logic [drbc_pkg::CountW-1:0] region_area;
  logic [drbc_pkg::CountW-1:0] boundary_count;

  modport source (output valid, output region_area, output boundary_count, input ready);
  modport sink   (input valid, input region_area, input boundary_count, output ready);
endinterface

// ===== hw/rtl/drbc_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module drbc_ram #(
  parameter  int unsigned Width = 1,
  parameter  int unsigned Depth = 2,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/drbc_front.sv =====
`timescale 1ns / 1ps
// Front end: config registers, raster position and per-pixel classification.
// Depends on drbc_pkg and drbc_pix_if.
module drbc_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [drbc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [drbc_pkg::CfgW-1:0]     cfg_data_i,
  drbc_pix_if.sink                      pix,
  input  logic                          q_full_i,
  output logic                          push_o,
  output drbc_pkg::item_t               item_o,
  output logic                          restart_o
);

  logic [drbc_pkg::CfgW-1:0] size_q, thr_q;
  logic [drbc_pkg::ColW-1:0] row_q, row_d, col_q, col_d;
  logic [drbc_pkg::ColW-1:0] nm1;
  logic                      row_end, col_end;

  // Effective side length minus one: zero counts as one, clamp to the maximum
  always_comb begin
    if (size_q == '0) begin
      nm1 = '0;
    end else if (32'(size_q) > 32'(drbc_pkg::MaxSize)) begin
      nm1 = drbc_pkg::ColW'(drbc_pkg::MaxSize - 1);
    end else begin
      nm1 = drbc_pkg::ColW'(size_q - 8'd1);
    end
  end

  assign row_end = (row_q == nm1);
  assign col_end = (col_q == nm1);

  assign pix.ready = !q_full_i;
  assign push_o    = pix.valid && !q_full_i;
  assign restart_o = cfg_we_i;

  always_comb begin
    item_o.dark      = (pix.pixel_value <= thr_q);
    item_o.first_row = (row_q == '0);
    item_o.first_col = (col_q == '0);
    item_o.border    = (row_q == '0) || (col_q == '0) || row_end || col_end;
    item_o.last      = row_end && col_end;
    item_o.col       = col_q;
  end

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (row_end && col_end) begin
      row_d = '0;
      col_d = '0;
    end else if (col_end) begin
      row_d = row_q + 1'b1;
      col_d = '0;
    end else begin
      col_d = col_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= drbc_pkg::SizeReset;
      thr_q  <= drbc_pkg::ThresholdReset;
      row_q  <= '0;
      col_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (drbc_pkg::cfg_reg_e'(cfg_idx_i))
        drbc_pkg::RegImageSize:     size_q <= cfg_data_i;
        drbc_pkg::RegDarkThreshold: thr_q  <= cfg_data_i;
      endcase
      row_q <= '0;
      col_q <= '0;
    end else if (push_o) begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

endmodule

// ===== hw/rtl/drbc_queue.sv =====
`timescale 1ns / 1ps
// Short FIFO of classified pixels between front and back.
// Depends on drbc_pkg.
module drbc_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  drbc_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output drbc_pkg::item_t head_o
);

  drbc_pkg::item_t            slot_q [drbc_pkg::QueueDepth];
  logic [drbc_pkg::QPtrW-1:0] wr_q, rd_q;
  logic [drbc_pkg::QCntW-1:0] cnt_q;

  function automatic logic [drbc_pkg::QPtrW-1:0] next_ptr(input logic [drbc_pkg::QPtrW-1:0] p);
    if (32'(p) == drbc_pkg::QueueDepth - 1) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign full_o  = (32'(cnt_q) == drbc_pkg::QueueDepth);
  assign valid_o = (cnt_q != '0);
  assign head_o  = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= next_ptr(wr_q);
      end
      if (pop_i) begin
        rd_q <= next_ptr(rd_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/drbc_back.sv =====
`timescale 1ns / 1ps
// Back end: line store lookup, boundary decisions, saturating totals, result register.
// Depends on drbc_pkg, drbc_res_if and drbc_ram.
module drbc_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            restart_i,
  input  logic            head_valid_i,
  input  drbc_pkg::item_t head_i,
  output logic            pop_o,
  drbc_res_if.source      res
);

  drbc_pkg::item_t             s_item_q;
  logic                        s_valid_q;
  logic                        byp_hit_q;
  drbc_pkg::line_t             byp_q;
  logic                        pend_valid_q;
  logic [drbc_pkg::ColW-1:0]   pend_col_q;
  logic                        pend_old_q, pend_new_q;
  logic [drbc_pkg::CountW-1:0] area_q, area_d, bnd_q, bnd_d;
  logic                        out_valid_q;
  logic [drbc_pkg::CountW-1:0] out_area_q, out_bnd_q;

  logic                        retire, advance, we;
  drbc_pkg::line_t             wdata, rdata, up;
  logic                        left_bright_hit, up_bright_hit, own_bnd;
  logic [1:0]                  inc;
  logic [drbc_pkg::CountW:0]   bnd_sum;

  assign retire  = s_valid_q && (!s_item_q.last || !out_valid_q || res.ready);
  assign advance = head_valid_i && (!s_valid_q || retire);
  assign pop_o   = advance;

  // The previous pixel's entry is written once its right neighbour is known
  assign we          = retire && pend_valid_q;
  assign wdata.older = pend_old_q && s_item_q.dark;
  assign wdata.newer = pend_new_q;

  drbc_ram #(
    .Width ($bits(drbc_pkg::line_t)),
    .Depth (drbc_pkg::MaxSize)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (pend_col_q),
    .wdata_i (wdata),
    .re_i    (advance),
    .raddr_i (head_i.col),
    .rdata_o (rdata)
  );

  assign up = byp_hit_q ? byp_q : rdata;

  always_comb begin
    up_bright_hit   = !s_item_q.first_row && up.older && !s_item_q.dark;
    left_bright_hit = !s_item_q.first_col && pend_old_q && !s_item_q.dark;
    own_bnd         = s_item_q.dark && (s_item_q.border || !up.newer || !pend_new_q);
    inc             = 2'(up_bright_hit) + 2'(left_bright_hit) + 2'(own_bnd);
    bnd_sum         = {1'b0, bnd_q} + (drbc_pkg::CountW + 1)'(inc);
    if (bnd_sum > {1'b0, drbc_pkg::CountMax}) begin
      bnd_d = drbc_pkg::CountMax;
    end else begin
      bnd_d = bnd_sum[drbc_pkg::CountW-1:0];
    end
    area_d = area_q;
    if (s_item_q.dark && (area_q != drbc_pkg::CountMax)) begin
      area_d = area_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s_item_q <= head_i;
      byp_q    <= wdata;
    end
    if (retire) begin
      pend_col_q <= s_item_q.col;
      pend_old_q <= s_item_q.dark && !own_bnd;
      pend_new_q <= s_item_q.dark;
    end
    if (retire && s_item_q.last) begin
      out_area_q <= area_d;
      out_bnd_q  <= bnd_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q    <= 1'b0;
      byp_hit_q    <= 1'b0;
      pend_valid_q <= 1'b0;
      area_q       <= '0;
      bnd_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (advance) begin
        s_valid_q <= 1'b1;
        byp_hit_q <= we && (pend_col_q == head_i.col);
      end else if (retire) begin
        s_valid_q <= 1'b0;
      end
      if (restart_i) begin
        pend_valid_q <= 1'b0;
        area_q       <= '0;
        bnd_q        <= '0;
      end else if (retire) begin
        pend_valid_q <= 1'b1;
        if (s_item_q.last) begin
          area_q <= '0;
          bnd_q  <= '0;
        end else begin
          area_q <= area_d;
          bnd_q  <= bnd_d;
        end
      end
      if (retire && s_item_q.last) begin
        out_valid_q <= 1'b1;
      end else if (res.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign res.valid          = out_valid_q;
  assign res.region_area    = out_area_q;
  assign res.boundary_count = out_bnd_q;

  // Every boundary pixel is also a region pixel
  a_bnd_le_area : assert property (@(posedge clk_i) disable iff (!rst_ni)
    bnd_q <= area_q)
    else $error("boundary total above area total");

  // A stalled pixel keeps its place in the decision stage
  a_stage_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_valid_q && !retire |=> s_valid_q && $stable(s_item_q))
    else $error("decision stage lost a pixel while stalled");

  // The last pixel of a frame always produces a result beat
  a_last_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    retire && s_item_q.last |=> res.valid)
    else $error("frame end without result");

  // A configuration write starts a fresh frame count
  a_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    restart_i |=> (area_q == '0) && (bnd_q == '0))
    else $error("totals not cleared on restart");

endmodule

// ===== hw/rtl/dark_region_area_and_boundary_count_unit.sv =====
`timescale 1ns / 1ps
// Dark region area and 4-neighbour boundary count. Totals are registered once a frame's
// last pixel leaves the decision stage. Throughput: one pixel per cycle, set by the
// line store's separate read and write ports; input stalls only once the queue fills
// behind a frame-end pixel whose result beat is still waiting to be taken.
// Reset: image size 1, threshold 50, frame restarts at row 0 column 0. Line stores are
// not cleared: row 0 never consults them. Depends on drbc_pkg, both interfaces, drbc_*.
module dark_region_area_and_boundary_count_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration: index 0 image size, index 1 dark threshold
  input  logic                         cfg_we_i,
  input  logic [drbc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [drbc_pkg::CfgW-1:0]    cfg_data_i,
  drbc_pix_if.sink                     pix_i,
  drbc_res_if.source                   res_o
);

  // Front classifies each pixel (dark, border, frame end) and tracks raster position.
  // The queue decouples it from the back, which holds the two one-bit line stores
  // packed into one small RAM and does the boundary bookkeeping.
  drbc_pkg::item_t front_item, head_item;
  logic            push, q_full, head_valid, pop, restart;

  drbc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pix        (pix_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .item_o     (front_item),
    .restart_o  (restart)
  );

  drbc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .head_o  (head_item)
  );

  // Back: the head pixel's column is looked up as it leaves the queue; the decision
  // stage then resolves its upper and left neighbours and updates the totals.
  drbc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .restart_i    (restart),
    .head_valid_i (head_valid),
    .head_i       (head_item),
    .pop_o        (pop),
    .res          (res_o)
  );

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Testbench for dark_region_area_and_boundary_count_unit: streams grey frames, predicts both
// frame totals in a scoreboard class and checks every result beat against them.
// Depends on drbc_pkg, drbc_pix_if, drbc_res_if and the unit itself.
module tb;

  localparam int unsigned RandomPixels = 1880;  // random pixels across the three idling modes
  localparam int unsigned StallPixels  = 40;    // size-1 frames pushed during the long hold
  localparam int unsigned LongHold     = 300;   // receiver hold-off, in cycles
  localparam int unsigned DrainCycles  = 8;     // settling time after the last frame total is taken
  localparam int unsigned MaxPrints    = 100;

  typedef struct packed {
    logic [drbc_pkg::CountW-1:0] area;
    logic [drbc_pkg::CountW-1:0] boundary;
  } frame_totals_t;

  // content mix of one frame
  typedef enum int unsigned {
    PixUniform,
    PixMostlyDark,
    PixNearThreshold,
    PixMostlyBright
  } pix_style_e;

  // which registers a reconfiguration touches, and in what order
  typedef enum int unsigned {
    WrBothSizeFirst,
    WrBothThrFirst,
    WrSizeOnly,
    WrThrOnly
  } cfg_plan_e;

  // Scoreboard: own copy of the line stores, position and totals; queues the totals that
  // each frame's last pixel should produce and compares them with the result beats.
  class region_totals_sb;
    bit                          dark_row[drbc_pkg::MaxSize];   // region bit, most recent row
    bit                          undecided[drbc_pkg::MaxSize];  // interior pixel awaiting below
    int unsigned                 row;
    int unsigned                 col;
    logic [drbc_pkg::CountW-1:0] area;
    logic [drbc_pkg::CountW-1:0] boundary;
    logic [drbc_pkg::CfgW-1:0]   size_reg;
    logic [drbc_pkg::CfgW-1:0]   thr_reg;
    frame_totals_t               totals_due[$];
    int unsigned                 errors;

    function new();
      foreach (dark_row[i]) begin
        dark_row[i]  = 1'b0;
        undecided[i] = 1'b0;
      end
      size_reg = drbc_pkg::SizeReset;
      thr_reg  = drbc_pkg::ThresholdReset;
      errors   = 0;
      restart();
    endfunction

    function void restart();
      row      = 0;
      col      = 0;
      area     = '0;
      boundary = '0;
    endfunction

    // zero reads as one, anything past the line store length as the full length
    function int unsigned side_px();
      if (size_reg == 0) return 1;
      if (32'(size_reg) > drbc_pkg::MaxSize) return drbc_pkg::MaxSize;
      return 32'(size_reg);
    endfunction

    function logic [drbc_pkg::CountW-1:0] sat_inc(logic [drbc_pkg::CountW-1:0] v);
      return (v == drbc_pkg::CountMax) ? v : v + 1'b1;
    endfunction

    function void set_reg(drbc_pkg::cfg_reg_e idx, logic [drbc_pkg::CfgW-1:0] data);
      if (idx == drbc_pkg::RegImageSize) size_reg = data;
      else                               thr_reg  = data;
      restart();
    endfunction

    function void note_pixel(logic [drbc_pkg::PixW-1:0] v);
      int unsigned n, r, c;
      bit          dark, up_dark, left_dark, border;
      n = side_px();
      r = (row >= n) ? n - 1 : row;
      c = (col >= n) ? n - 1 : col;
      dark      = (v <= thr_reg);
      up_dark   = 1'b0;
      left_dark = 1'b0;
      // pixel above now has its lower neighbour
      if (r > 0) begin
        up_dark = dark_row[c];
        if (undecided[c] && !dark) boundary = sat_inc(boundary);
      end
      // pixel to the left now has its right neighbour
      if (c > 0) begin
        left_dark = dark_row[c-1];
        if (undecided[c-1] && !dark) begin
          boundary       = sat_inc(boundary);
          undecided[c-1] = 1'b0;
        end
      end
      undecided[c] = 1'b0;
      dark_row[c]  = dark;
      if (dark) begin
        area   = sat_inc(area);
        border = (r == 0) || (c == 0) || (r == n - 1) || (c == n - 1);
        if (border || !up_dark || !left_dark) boundary = sat_inc(boundary);
        else                                  undecided[c] = 1'b1;
      end
      if (r == n - 1 && c == n - 1) begin
        totals_due.push_back('{area: area, boundary: boundary});
        restart();
      end else if (c + 1 >= n) begin
        col = 0;
        row = r + 1;
      end else begin
        col = c + 1;
        row = r;
      end
    endfunction

    task log_mismatch(string msg);
      errors++;
      if (errors <= MaxPrints) $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task check_totals(logic [drbc_pkg::CountW-1:0] got_area,
                      logic [drbc_pkg::CountW-1:0] got_bnd);
      frame_totals_t want;
      if (totals_due.size() == 0) begin
        log_mismatch($sformatf("result beat area=%0d boundary=%0d with no frame pending",
                               got_area, got_bnd));
        return;
      end
      want = totals_due.pop_front();
      if (got_area !== want.area)
        log_mismatch($sformatf("region_area %0d, expected %0d", got_area, want.area));
      if (got_bnd !== want.boundary)
        log_mismatch($sformatf("boundary_count %0d, expected %0d", got_bnd, want.boundary));
    endtask
  endclass

  logic                         clk;
  logic                         rst_n = 1'b0;
  logic                         cfg_we;
  logic [drbc_pkg::CfgIdxW-1:0] cfg_idx;
  logic [drbc_pkg::CfgW-1:0]    cfg_data;
  int unsigned                  src_idle_pct  = 0;
  int unsigned                  sink_idle_pct = 0;
  logic                         hold_start = 1'b0;
  logic                         hold_rx    = 1'b0;
  int unsigned                  pixels_sent = 0;
  region_totals_sb              sb;

  drbc_pix_if pix ();
  drbc_res_if res ();

  dark_region_area_and_boundary_count_unit u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .pix_i      (pix),
    .res_o      (res)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Receiver: random back-pressure per idling mode, forced low during the long hold
  always @(posedge clk) begin
    if (!rst_n || hold_rx) res.ready <= 1'b0;
    else                   res.ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // Long hold-off, timed here so the sender can keep offering pixels meanwhile
  initial begin : long_hold
    wait (hold_start);
    @(posedge clk);
    hold_rx <= 1'b1;
    repeat (LongHold) @(posedge clk);
    hold_rx <= 1'b0;
  end

  // Result monitor: beat taken on valid & ready at the rising edge
  always @(posedge clk) begin
    if (rst_n && res.valid && res.ready) sb.check_totals(res.region_area, res.boundary_count);
  end

  function automatic logic [drbc_pkg::PixW-1:0] pick_pixel(pix_style_e style,
                                                           int unsigned thr);
    int unsigned roll;
    roll = $urandom_range(99);
    case (style)
      PixUniform: return drbc_pkg::PixW'($urandom_range(255));
      PixMostlyDark: begin
        if (roll < 80 || thr == 255) return drbc_pkg::PixW'($urandom_range(thr));
        return drbc_pkg::PixW'($urandom_range(255, thr + 1));
      end
      PixNearThreshold: begin
        if (roll < 40) return drbc_pkg::PixW'(thr);
        if (roll < 70) return drbc_pkg::PixW'((thr == 255) ? 255 : thr + 1);
        if (roll < 85) return drbc_pkg::PixW'((thr == 0) ? 0 : thr - 1);
        return roll[0] ? 8'hff : 8'h00;
      end
      default: begin
        if (roll < 80 && thr < 255) return drbc_pkg::PixW'($urandom_range(255, thr + 1));
        return drbc_pkg::PixW'($urandom_range(thr));
      end
    endcase
  endfunction

  // One pixel beat; random gaps first, then hold valid until it is taken
  task automatic send_pixel(logic [drbc_pkg::PixW-1:0] v);
    while ($urandom_range(99) < src_idle_pct) begin
      pix.valid <= 1'b0;
      @(posedge clk);
    end
    pix.valid       <= 1'b1;
    pix.pixel_value <= v;
    @(posedge clk);
    while (!pix.ready) @(posedge clk);
    sb.note_pixel(v);
    pixels_sent++;
  endtask

  task automatic send_pixels(int unsigned count, pix_style_e style);
    for (int unsigned i = 0; i < count; i++) send_pixel(pick_pixel(style, 32'(sb.thr_reg)));
  endtask

  // Stop offering, wait for every pending frame total, then let the pipeline empty
  task automatic drain();
    pix.valid <= 1'b0;
    while (sb.totals_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(drbc_pkg::cfg_reg_e idx, logic [drbc_pkg::CfgW-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    sb.set_reg(idx, data);
    @(posedge clk);
  endtask

  // Only called with the unit idle; every write restarts the frame
  task automatic configure(logic [drbc_pkg::CfgW-1:0] side, logic [drbc_pkg::CfgW-1:0] thr,
                           cfg_plan_e plan);
    case (plan)
      WrBothSizeFirst: begin
        write_reg(drbc_pkg::RegImageSize, side);
        write_reg(drbc_pkg::RegDarkThreshold, thr);
      end
      WrBothThrFirst: begin
        write_reg(drbc_pkg::RegDarkThreshold, thr);
        write_reg(drbc_pkg::RegImageSize, side);
      end
      WrSizeOnly: write_reg(drbc_pkg::RegImageSize, side);
      default:    write_reg(drbc_pkg::RegDarkThreshold, thr);
    endcase
    cfg_we <= 1'b0;
  endtask

  // Several whole frames back to back under one setting, sometimes cut short at the end;
  // never goes past the pixel count given by target
  task automatic random_phase(int unsigned target);
    int unsigned roll, side, n, frames, count;
    logic [drbc_pkg::CfgW-1:0] thr;
    roll = $urandom_range(99);
    if      (roll < 2)  side = 0;
    else if (roll < 70) side = $urandom_range(8, 1);
    else if (roll < 95) side = $urandom_range(16, 9);
    else                side = $urandom_range(24, 17);
    roll = $urandom_range(99);
    if      (roll < 10) thr = 8'h00;
    else if (roll < 20) thr = 8'hff;
    else                thr = drbc_pkg::CfgW'($urandom_range(255));
    configure(drbc_pkg::CfgW'(side), thr, cfg_plan_e'($urandom_range(3)));
    n      = (side == 0) ? 1 : side;
    frames = $urandom_range(4, 1);
    for (int unsigned f = 0; f < frames && pixels_sent < target; f++) begin
      count = n * n;
      // broken frame: left unfinished, the next write restarts it
      if (f == frames - 1 && n > 1 && $urandom_range(99) < 15)
        count = $urandom_range(n * n - 1, 1);
      if (count > target - pixels_sent) count = target - pixels_sent;
      send_pixels(count, pix_style_e'($urandom_range(3)));
    end
    drain();
  endtask

  initial begin : stimulus
    int unsigned target;
    pix.valid       = 1'b0;
    pix.pixel_value = '0;
    cfg_we          = 1'b0;
    cfg_idx         = drbc_pkg::RegImageSize;
    cfg_data        = '0;
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed ---
    src_idle_pct  = 27;
    sink_idle_pct = 55;
    // reset settings: 1x1 frame, threshold 50; on, just above and well below threshold
    send_pixel(8'd50);
    send_pixel(8'd51);
    send_pixel(8'd0);
    drain();
    // size zero reads as one
    configure(8'd0, 8'd0, WrSizeOnly);
    send_pixel(8'd0);
    drain();
    // partial 3x3 frame, then a threshold write must restart it
    configure(8'd3, 8'd100, WrBothSizeFirst);
    send_pixel(8'd0);
    send_pixel(8'd0);
    send_pixel(8'd0);
    drain();
    // threshold 0, all black: centre pixel is interior, not boundary
    configure(8'd3, 8'd0, WrThrOnly);
    for (int i = 0; i < 9; i++) send_pixel(8'd0);
    drain();
    // threshold 255, all white still counts as region
    configure(8'd3, 8'd255, WrThrOnly);
    for (int i = 0; i < 9; i++) send_pixel(8'd255);
    drain();

    // --- back-pressure: receiver holds off while 1x1 frames keep coming ---
    configure(8'd1, 8'd128, WrBothThrFirst);
    hold_start <= 1'b1;
    send_pixels(StallPixels, PixUniform);
    drain();

    // --- random, over three idling modes ---
    for (int m = 0; m < 3; m++) begin
      src_idle_pct  = (m == 0) ? 27 : (m == 1) ? 55 : 0;
      sink_idle_pct = (m == 0) ? 55 : (m == 1) ? 27 : 0;
      target = pixels_sent + RandomPixels / 3;
      while (pixels_sent < target) random_phase(target);
    end

    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog: fails the run if it has not finished by the time limit
  initial begin : watchdog
    #4ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/drbc_pkg.sv
hw/rtl/drbc_pix_if.sv
hw/rtl/drbc_res_if.sv
hw/rtl/drbc_ram.sv
hw/rtl/drbc_front.sv
hw/rtl/drbc_queue.sv
hw/rtl/drbc_back.sv
hw/rtl/dark_region_area_and_boundary_count_unit.sv
dv/tb.sv
